// ===== hw/rtl/cksum_pkg.sv =====
package cksum_pkg;

  // Generator polynomial and top bit of the MSB-first CRC.
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_TOP  = 32'h8000_0000;

  // Controller states.
  typedef enum logic {
    ST_RUN,
    ST_LEN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic fold_len;
    logic load_result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_zero;
  } status_t;

  // Fold one byte into the CRC, eight shift steps of the polynomial division.
  function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      if ((r & CRC_TOP) != 32'h0) begin
        r = (r << 1) ^ CRC_POLY;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/cksum_ctrl.sv =====
module cksum_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  input  logic              out_ready,
  input  cksum_pkg::status_t status,
  output logic              in_ready,
  output logic              out_valid,
  output cksum_pkg::cmd_t   cmd
);
  import cksum_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands. Bytes stream in ST_RUN; ST_LEN folds the length
  // bytes and then hands the result to the output register once it is free.
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state)
      ST_RUN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          if (in_last) begin
            state_next = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (!status.rem_zero) begin
          cmd.fold_len = 1'b1;
        end else if (!out_valid || out_ready) begin
          cmd.load_result = 1'b1;
          state_next      = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase

    // The output register holds its transaction until the receiver takes it.
    if (cmd.load_result) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== hw/rtl/cksum_dpath.sv =====
module cksum_dpath #(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  cksum_pkg::cmd_t    cmd,
  input  logic [7:0]         data_byte,
  input  logic               has_byte,
  input  logic               last,
  output cksum_pkg::status_t status,
  output logic [31:0]        checksum,
  output logic [31:0]        message_length
);
  import cksum_pkg::*;

  logic [31:0]           crc;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] rem;

  // Count including the byte of the current transaction, if it carries one.
  assign count_next = has_byte ? (count + COUNT_BITS'(1)) : count;

  assign status.rem_zero = (rem == '0);

  // Running CRC and byte count; cleared on reset and when a result is loaded into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= 32'h0;
      count <= '0;
    end else if (cmd.load_result) begin
      crc   <= 32'h0;
      count <= '0;
    end else if (cmd.take_item) begin
      if (has_byte) begin
        crc <= fold_byte(crc, data_byte);
      end
      count <= count_next;
    end else if (cmd.fold_len) begin
      crc <= fold_byte(crc, rem[7:0]);
    end
  end

  // Remaining length, shifted out one byte at a time, least significant first.
  always_ff @(posedge clk) begin
    if (cmd.take_item && last) begin
      rem <= count_next;
    end else if (cmd.fold_len) begin
      rem <= rem >> 8;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      checksum       <= ~crc;
      message_length <= 32'(count);
    end
  end

endmodule

// ===== hw/rtl/crc32_length_appended_checksum_core.sv =====
// POSIX cksum checksum engine.
// Input channel (in_valid/in_ready): each transaction carries
// data_byte, has_byte and last. A byte is folded into the MSB-first CRC
// (polynomial 0x04C11DB7, zero start) when has_byte is high; last closes the
// message, with or without a byte of its own.
// Output channel (out_valid/out_ready): one transaction per message, giving
// the inverted CRC after the length bytes and the byte count modulo
// 2^COUNT_BITS.
// Throughput: data transactions are taken at one per cycle. After a closing
// transaction the input is held off while the k significant length bytes
// (k from 0 to ceil(COUNT_BITS/8)) are folded into the CRC one after another,
// and until the result can be loaded into the output register.
// Reset clears the CRC, the count and the output valid. A stalled receiver
// does not block the next message's bytes: the result sits in its output
// register, and only after the next closing transaction is the input held
// until that result is taken.
module crc32_length_appended_checksum_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] checksum,
  output logic [31:0] message_length
);
  import cksum_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing of message bytes, length folding and result hand-off.
  cksum_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (last),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // CRC, count and output registers.
  cksum_dpath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .last           (last),
    .status         (status),
    .checksum       (checksum),
    .message_length (message_length)
  );

endmodule

// ===== hw/rtl/cksum_chk.sv =====
module cksum_chk #(
  parameter int COUNT_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic        has_byte,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] checksum,
  input logic [31:0] message_length
);

  // A waiting input transaction keeps its valid and payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=>
      in_valid && $stable(data_byte) && $stable(has_byte) && $stable(last))
    else $error("input changed while waiting");

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(checksum) && $stable(message_length))
    else $error("result changed while stalled");

  // A closing transaction is followed by a stall of the input.
  a_close_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("input taken while closing a message");

  // A new result only comes out of the length-folding phase.
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a closing transaction");

  // The reported length fits the counter.
  a_length_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((message_length >> COUNT_BITS) == 32'h0))
    else $error("message length beyond counter width");

endmodule

bind crc32_length_appended_checksum_core cksum_chk #(.COUNT_BITS(COUNT_BITS)) u_chk (.*);
